// ===== design/rsl_pkg.sv =====
// rsl_pkg: shared types, codes and constants for the rgb status led pattern block
// no dependencies; used by rsl_div, rsl_scale and rgb_status_led_pattern
package rsl_pkg;

  localparam int unsigned LvlW     = 8;
  localparam int unsigned MsW      = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // divider: numerator is 510 * x with x below 2^16, denominator is the ramp length
  localparam int unsigned NumW     = 25;
  localparam int unsigned DenW     = MsW;
  localparam int unsigned DivSteps = LvlW + 1;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  localparam logic [LvlW-1:0] LvlMax = {LvlW{1'b1}};

  // status modes
  localparam logic [ModeW-1:0] MODE_STANDBY  = 3'd0;
  localparam logic [ModeW-1:0] MODE_OFF      = 3'd1;
  localparam logic [ModeW-1:0] MODE_TRANSMIT = 3'd2;
  localparam logic [ModeW-1:0] MODE_RECEIVE  = 3'd3;
  localparam logic [ModeW-1:0] MODE_BUSY     = 3'd4;
  localparam logic [ModeW-1:0] MODE_ERROR    = 3'd5;
  localparam logic [ModeW-1:0] MODE_BLINK    = 3'd6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BREATHE_ON  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BREATHE_OFF = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLINK_ON    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BLINK_OFF   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CATHODE     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DIM_SCALE   = 3'd5;

  typedef logic [LvlW-1:0] lvl_t;
  // index 0 red, 1 green, 2 blue
  typedef lvl_t [2:0] rgb_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic       done;
    lvl_t       quo;
  } div_rsp_t;

  // blink colour of a mode, as fractions over 255
  function automatic rgb_t mode_colour(logic [ModeW-1:0] mode);
    rgb_t c;
    case (mode)
      MODE_TRANSMIT: c = {8'd255, 8'd0,   8'd0};
      MODE_RECEIVE:  c = {8'd227, 8'd43,  8'd138};
      MODE_BUSY:     c = {8'd255, 8'd255, 8'd0};
      MODE_ERROR:    c = {8'd0,   8'd0,   8'd255};
      MODE_BLINK:    c = {8'd255, 8'd255, 8'd255};
      default:       c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/rgb_status_led_pattern.sv =====
// rgb_status_led_pattern: status pattern for one rgb led, one poll item at a time
// depends on rsl_pkg, rsl_div, rsl_scale
//
// Each poll item carries the millisecond time, a status mode and a dim flag, and
// yields zero or one item of three pwm levels. The block takes one poll at a time:
// s_axis_tready is high only while it is idle. A poll with a fixed pattern (off
// mode, breathe pause, blink going dark) goes from S_EVAL straight to S_OUT; a
// blink going lit, or a breathe poll past the end of the ramp, passes its three
// colour channels one by one through the single 8x8 multiplier, S_MUL then S_LVL
// for each; a breathe ramp poll first runs the nine-step divider in S_DIV, then
// the three multiplier passes. The block is idle again at the edge that takes
// the result and only then accepts the next poll, so it takes no new poll
// before the last one has left. A poll without a result goes from S_EVAL back
// to S_IDLE. Configuration writes are taken at any time but belong in idle
// periods.
module rgb_status_led_pattern (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rsl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rsl_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,   // now_ms[31:0]
  input  logic [3:0]                     s_axis_tuser,   // mode[2:0], dim[3]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);
  import rsl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_LVL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [MsW-1:0] on_q, boff_q, lon_q, loff_q;
  logic           cath_q;
  lvl_t           dsc_q;

  // pattern state
  logic [TimeW-1:0] ps_q, ps_d, be_q, be_d;
  logic             lit_q, lit_d;
  rgb_t             frac_q, frac_d;

  // item working registers
  logic [TimeW-1:0] now_q, now_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic             dim_q, dim_d;
  rgb_t             src_q, src_d, lvl_q, lvl_d;
  logic [1:0]       ch_q, ch_d;

  // datapath terms
  logic [TimeW-1:0] elapsed;
  logic [DenW-1:0]  den, x;
  logic [MsW:0]     cycle_len;
  logic             rising, past_end, has_colour;
  rgb_t             colour;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     scl_load;
  lvl_t     scl_factor, scl_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q   <= 16'd2000;
      boff_q <= 16'd1000;
      lon_q  <= 16'd100;
      loff_q <= 16'd900;
      cath_q <= 1'b1;
      dsc_q  <= 8'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BREATHE_ON:  on_q   <= cfg_wdata_i;
        CFG_BREATHE_OFF: boff_q <= cfg_wdata_i;
        CFG_BLINK_ON:    lon_q  <= cfg_wdata_i;
        CFG_BLINK_OFF:   loff_q <= cfg_wdata_i;
        CFG_CATHODE:     cath_q <= cfg_wdata_i[0];
        CFG_DIM_SCALE:   dsc_q  <= cfg_wdata_i[LvlW-1:0];
        default: ;
      endcase
    end
  end

  assign elapsed   = now_q - ps_q;
  assign den       = (on_q == '0) ? DenW'(1) : on_q;
  assign rising    = elapsed <= {{(TimeW-MsW+1){1'b0}}, on_q[MsW-1:1]};
  assign past_end  = elapsed >= {{(TimeW-DenW){1'b0}}, den};
  // rising edge of the ramp uses the elapsed time, falling edge the time left
  assign x         = rising ? elapsed[DenW-1:0] : den - elapsed[DenW-1:0];
  assign cycle_len = {1'b0, on_q} + {1'b0, boff_q};
  assign colour    = mode_colour(mode_q);

  always_comb begin
    case (mode_q)
      MODE_TRANSMIT, MODE_RECEIVE, MODE_BUSY, MODE_ERROR, MODE_BLINK: has_colour = 1'b1;
      default: has_colour = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    ps_d    = ps_q;
    be_d    = be_q;
    lit_d   = lit_q;
    frac_d  = frac_q;
    now_d   = now_q;
    mode_d  = mode_q;
    dim_d   = dim_q;
    src_d   = src_q;
    lvl_d   = lvl_q;
    ch_d    = ch_q;

    div_req.start = 1'b0;
    div_req.num   = {x, 9'd0} - {8'd0, x, 1'b0};   // 510 * x
    div_req.den   = den;
    scl_load      = 1'b0;
    scl_factor    = dim_q ? dsc_q : LvlMax;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          now_d   = s_axis_tdata;
          mode_d  = s_axis_tuser[ModeW-1:0];
          dim_d   = s_axis_tuser[ModeW];
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        src_d = '0;
        ch_d  = '0;
        if (mode_q == MODE_STANDBY) begin
          if (be_q <= {{(TimeW-MsW){1'b0}}, on_q}) begin
            be_d = elapsed;
            if (!rising && past_end) begin
              state_d = S_MUL;               // ramp finished, all fractions zero
            end else begin
              div_req.start = 1'b1;
              state_d       = S_DIV;
            end
          end else begin
            lvl_d   = {3{LvlMax}};
            state_d = S_OUT;
            if (be_q <= {{(TimeW-MsW-1){1'b0}}, cycle_len}) begin
              be_d = elapsed;
            end else begin
              ps_d = now_q;
              be_d = '0;
            end
          end
        end else if (mode_q == MODE_OFF) begin
          lvl_d   = cath_q ? {3{LvlMax}} : '0;
          state_d = S_OUT;
        end else if (!lit_q && elapsed > {{(TimeW-MsW){1'b0}}, loff_q}) begin
          lit_d = 1'b1;
          ps_d  = now_q;
          // unused mode code keeps the fractions already held
          if (has_colour) begin
            frac_d = cath_q ? colour : ~colour;
          end
          src_d   = frac_d;
          state_d = S_MUL;
        end else if (lit_q && elapsed > {{(TimeW-MsW){1'b0}}, lon_q}) begin
          lit_d   = 1'b0;
          ps_d    = now_q;
          lvl_d   = {3{LvlMax}};
          state_d = S_OUT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          src_d[1] = div_rsp.quo;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        scl_load = 1'b1;
        state_d  = S_LVL;
      end
      S_LVL: begin
        lvl_d[ch_q] = ~scl_res;
        if (ch_q == 2'd2) begin
          state_d = S_OUT;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ps_q    <= '0;
      be_q    <= '0;
      lit_q   <= 1'b0;
      frac_q  <= '0;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      ps_q    <= ps_d;
      be_q    <= be_d;
      lit_q   <= lit_d;
      frac_q  <= frac_d;
      ch_q    <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    mode_q <= mode_d;
    dim_q  <= dim_d;
    src_q  <= src_d;
    lvl_q  <= lvl_d;
  end

  rsl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rsl_scale u_scale (
    .clk_i    (clk_i),
    .load_i   (scl_load),
    .val_i    (src_q[ch_q]),
    .factor_i (scl_factor),
    .res_o    (scl_res)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = lvl_q;

endmodule

// ===== design/rsl_div.sv =====
// rsl_div: restoring divider, one compare-subtract per cycle,
// quotient saturated to 255; depends on rsl_pkg
module rsl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rsl_pkg::div_req_t  req_i,
  output rsl_pkg::div_rsp_t  rsp_o
);
  import rsl_pkg::*;

  logic [NumW-1:0]     rem_q, den_q, diff;
  logic [DivSteps-1:0] quo_q;
  logic [DivCntW-1:0]  cnt_q;
  logic                busy_q, done_q, ge;

  assign ge   = rem_q >= den_q;
  assign diff = rem_q - den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // first step tests den << 8: a hit there means the quotient exceeds 255
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      den_q <= {1'b0, req_i.den, {LvlW{1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= diff;
      end
      quo_q <= {quo_q[DivSteps-2:0], ge};
      den_q <= den_q >> 1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q[DivSteps-1] ? LvlMax : quo_q[LvlW-1:0];

endmodule

// ===== design/rsl_scale.sv =====
// rsl_scale: 8x8 multiply with registered product, then exact floor divide by 255
// depends on rsl_pkg
module rsl_scale (
  input  logic              clk_i,
  input  logic              load_i,
  input  rsl_pkg::lvl_t     val_i,
  input  rsl_pkg::lvl_t     factor_i,
  output rsl_pkg::lvl_t     res_o
);
  import rsl_pkg::*;

  logic [2*LvlW-1:0] prod_q;
  logic [2*LvlW:0]   sum;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= {{LvlW{1'b0}}, val_i} * {{LvlW{1'b0}}, factor_i};
    end
  end

  // floor(p / 255) = (p + (p >> 8) + 1) >> 8 for any product of two 8-bit values
  assign sum   = {1'b0, prod_q} + {{(LvlW+1){1'b0}}, prod_q[2*LvlW-1:LvlW]}
               + {{(2*LvlW){1'b0}}, 1'b1};
  assign res_o = sum[2*LvlW-1:LvlW];

endmodule

// ===== bench/rgb_status_led_pattern_tb.sv =====
// rgb_status_led_pattern_tb: self-checking bench for the rgb status led pattern block
// depends on rsl_pkg and rgb_status_led_pattern; poll items go in on the slave stream,
// level items come back on the master stream and are checked against a local model
module rgb_status_led_pattern_tb;
  import rsl_pkg::*;

  // mode code seven has no colour of its own
  localparam logic [ModeW-1:0] MODE_SPARE = 3'd7;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems  = 195;

  typedef struct packed {
    logic [TimeW-1:0] now;
    logic [ModeW-1:0] mode;
    logic             dim;
  } poll_t;

  typedef struct packed {
    lvl_t red;
    lvl_t green;
    lvl_t blue;
  } levels_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;   // now_ms[31:0]
  logic [3:0]          s_axis_tuser;   // mode[2:0], dim[3]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [23:0]         m_axis_tdata;   // red[7:0], green[15:8], blue[23:16]

  rgb_status_led_pattern dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // register copies
  logic [MsW-1:0]   ramp_ms, pause_ms, lit_ms, dark_ms;
  logic             cathode;
  logic [LvlW-1:0]  dim_scale;

  // pattern state
  logic [TimeW-1:0] phase_start, ramp_elapsed;
  logic             lit;
  lvl_t             frac [3];

  poll_t   polls_pending [$];
  levels_t levels_due [$];

  logic [TimeW-1:0] ms_cursor = '0;
  logic [ModeW-1:0] run_mode = MODE_STANDBY;
  int unsigned run_left = 0;

  int unsigned errors = 0, results_seen = 0, quiet = 0;
  int unsigned tx_gap = 0, rx_gap = 0, hold_left = 0;
  bit hold_armed = 1'b1, tx_calm = 1'b0, rx_calm = 1'b0, poll_taken = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic lvl_t dimmed(lvl_t f, logic dim);
    return dim ? lvl_t'((16'(f) * 16'(dim_scale)) / 16'd255) : f;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(40, 150);
  endfunction

  task automatic predict_levels(input poll_t p);
    logic [63:0] ramp_t, den, lvl;
    logic [TimeW-1:0] since;
    lvl_t colour [3];
    logic has_colour;
    levels_t lv;
    lv = '{red: LvlMax, green: LvlMax, blue: LvlMax};
    if (p.mode == MODE_STANDBY) begin
      if (ramp_elapsed <= 32'(ramp_ms)) begin
        den = (ramp_ms == '0) ? 64'd1 : 64'(ramp_ms);
        ramp_elapsed = p.now - phase_start;
        ramp_t = 64'(ramp_elapsed) * 64'd510;
        // rising half, then falling half down to zero
        if (ramp_elapsed <= 32'(ramp_ms >> 1)) lvl = ramp_t / den;
        else if (ramp_t >= 64'd510 * den) lvl = '0;
        else lvl = (64'd510 * den - ramp_t) / den;
        if (lvl > 64'd255) lvl = 64'd255;
        lv.green = LvlMax - dimmed(lvl_t'(lvl), p.dim);
      end else if (33'(ramp_elapsed) <= 33'(ramp_ms) + 33'(pause_ms)) begin
        ramp_elapsed = p.now - phase_start;
      end else begin
        phase_start = p.now;
        ramp_elapsed = '0;
      end
      levels_due.push_back(lv);
    end else if (p.mode == MODE_OFF) begin
      if (!cathode) lv = '0;
      levels_due.push_back(lv);
    end else begin
      since = p.now - phase_start;
      if (!lit && since > 32'(dark_ms)) begin
        lit = 1'b1;
        has_colour = 1'b1;
        case (p.mode)
          MODE_TRANSMIT: colour = '{8'd0, 8'd0, 8'd255};
          MODE_RECEIVE:  colour = '{8'd138, 8'd43, 8'd227};
          MODE_BUSY:     colour = '{8'd0, 8'd255, 8'd255};
          MODE_ERROR:    colour = '{8'd255, 8'd0, 8'd0};
          MODE_BLINK:    colour = '{8'd255, 8'd255, 8'd255};
          default:       has_colour = 1'b0;
        endcase
        // the spare mode keeps whatever fractions are held
        if (has_colour) begin
          for (int i = 0; i < 3; i++) frac[i] = cathode ? colour[i] : LvlMax - colour[i];
        end
        lv.red   = LvlMax - dimmed(frac[0], p.dim);
        lv.green = LvlMax - dimmed(frac[1], p.dim);
        lv.blue  = LvlMax - dimmed(frac[2], p.dim);
        phase_start = p.now;
        levels_due.push_back(lv);
      end else if (lit && since > 32'(lit_ms)) begin
        lit = 1'b0;
        phase_start = p.now;
        levels_due.push_back(lv);
      end
    end
  endtask

  // poll driver
  always @(negedge clk_i) begin
    poll_t p;
    if (rst_ni && !(s_axis_tvalid && !poll_taken)) begin
      poll_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (polls_pending.size() > 0) begin
        p = polls_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p.now;
        s_axis_tuser  <= {p.dim, p.mode};
        tx_gap = tx_calm ? 0 : pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // level receiver, with one long hold-off once traffic is flowing
  always @(negedge clk_i) begin
    if (hold_armed && results_seen >= 300) begin
      hold_armed = 1'b0;
      hold_left = 600;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_calm) begin
      m_axis_tready <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      rx_gap = pick_gap();
    end
  end

  // accept tracking, level checking and watchdog
  always @(posedge clk_i) begin
    levels_t want;
    bit moved;
    moved = cfg_we_i;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_levels('{now: s_axis_tdata, mode: s_axis_tuser[2:0], dim: s_axis_tuser[3]});
      poll_taken = 1'b1;
      moved = 1'b1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      moved = 1'b1;
      results_seen++;
      if (levels_due.size() == 0) begin
        $error("level item with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = levels_due.pop_front();
        if (m_axis_tdata[7:0] !== want.red) begin
          $error("red_level expected %0d got %0d", want.red, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[15:8] !== want.green) begin
          $error("green_level expected %0d got %0d", want.green, m_axis_tdata[15:8]);
          errors++;
        end
        if (m_axis_tdata[23:16] !== want.blue) begin
          $error("blue_level expected %0d got %0d", want.blue, m_axis_tdata[23:16]);
          errors++;
        end
      end
    end
    quiet = moved ? 0 : quiet + 1;
    if (quiet >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BREATHE_ON:  ramp_ms = val;
      CFG_BREATHE_OFF: pause_ms = val;
      CFG_BLINK_ON:    lit_ms = val;
      CFG_BLINK_OFF:   dark_ms = val;
      CFG_CATHODE:     cathode = val[0];
      CFG_DIM_SCALE:   dim_scale = val[LvlW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [MsW-1:0] ramp, pause, on, off,
                            input logic cath, input logic [LvlW-1:0] scale);
    write_reg(CFG_BREATHE_ON, ramp);
    write_reg(CFG_BREATHE_OFF, pause);
    write_reg(CFG_BLINK_ON, on);
    write_reg(CFG_BLINK_OFF, off);
    write_reg(CFG_CATHODE, CfgDataW'(cath));
    write_reg(CFG_DIM_SCALE, CfgDataW'(scale));
  endtask

  task automatic add_poll(input logic [TimeW-1:0] now, input logic [ModeW-1:0] mode,
                          input logic dim);
    polls_pending.push_back('{now: now, mode: mode, dim: dim});
  endtask

  // mostly runs of one mode with time steps sized to the active pattern, some noise
  task automatic add_random_polls(input int unsigned count);
    int unsigned r, span;
    logic [ModeW-1:0] mode;
    for (int unsigned i = 0; i < count; i++) begin
      if (run_left == 0) begin
        r = $urandom_range(0, 9);
        if (r < 3) run_mode = MODE_STANDBY;
        else if (r == 3) run_mode = MODE_OFF;
        else if (r == 9) run_mode = MODE_SPARE;
        else run_mode = ModeW'($urandom_range(MODE_TRANSMIT, MODE_BLINK));
        run_left = $urandom_range(3, 40);
      end
      run_left--;
      mode = ($urandom_range(0, 19) == 0) ? ModeW'($urandom) : run_mode;
      span = (mode == MODE_STANDBY) ? 32'(ramp_ms) + 32'(pause_ms)
                                    : 32'(lit_ms) + 32'(dark_ms);
      r = $urandom_range(0, 99);
      if (r < 55) ms_cursor += $urandom_range(0, span / 16 + 2);
      else if (r < 92) ms_cursor += $urandom_range(0, span + span / 4 + 2);
      else if (r < 97) ms_cursor += $urandom;
      else ms_cursor = $urandom;
      add_poll(ms_cursor, mode, 1'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (polls_pending.size() > 0 || s_axis_tvalid || levels_due.size() > 0)
      @(posedge clk_i);
    // polls without a result may still be in flight
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_BREATHE_ON;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    ramp_ms       = 16'd2000;
    pause_ms      = 16'd1000;
    lit_ms        = 16'd100;
    dark_ms       = 16'd900;
    cathode       = 1'b1;
    dim_scale     = 8'd64;
    phase_start   = '0;
    ramp_elapsed  = '0;
    lit           = 1'b0;
    frac          = '{default: '0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // breathe ramp up, peak, down, end and pause
    add_poll(32'd0, MODE_STANDBY, 1'b0);
    add_poll(32'd500, MODE_STANDBY, 1'b0);
    add_poll(32'd1000, MODE_STANDBY, 1'b1);
    add_poll(32'd1600, MODE_STANDBY, 1'b0);
    add_poll(32'd2000, MODE_STANDBY, 1'b0);
    add_poll(32'd2400, MODE_STANDBY, 1'b0);
    add_poll(32'd3500, MODE_STANDBY, 1'b0);
    add_poll(32'd3500, MODE_OFF, 1'b0);
    add_poll(32'd3501, MODE_OFF, 1'b1);
    // each blink colour goes lit, then dark; transmit also stays lit on a poll between
    add_poll(32'd5000, MODE_TRANSMIT, 1'b0);
    add_poll(32'd5050, MODE_TRANSMIT, 1'b0);
    add_poll(32'd5200, MODE_TRANSMIT, 1'b0);
    add_poll(32'd6200, MODE_RECEIVE, 1'b1);
    add_poll(32'd6400, MODE_RECEIVE, 1'b1);
    add_poll(32'd7400, MODE_BUSY, 1'b0);
    add_poll(32'd7600, MODE_BUSY, 1'b0);
    add_poll(32'd8600, MODE_ERROR, 1'b1);
    add_poll(32'd8800, MODE_ERROR, 1'b0);
    add_poll(32'd9800, MODE_BLINK, 1'b0);
    add_poll(32'd10000, MODE_BLINK, 1'b1);
    // spare mode reuses the held colour
    add_poll(32'd11000, MODE_SPARE, 1'b0);
    add_poll(32'd11200, MODE_SPARE, 1'b1);
    // time wrapping past the top
    add_poll(32'hFFFF_FFFF, MODE_BLINK, 1'b1);
    add_poll(32'h0000_0064, MODE_BLINK, 1'b0);
    add_poll(32'h8000_0000, MODE_STANDBY, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_config(16'd2, 16'd0, 16'd0, 16'd0, 1'b0, 8'd0);
        1: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'd255);
        2: set_config(16'd0, 16'd5, 16'd3, 16'd7, 1'b1, 8'd128);   // zero ramp length
        3: set_config(16'd1, 16'd1, 16'd1, 16'd2, 1'b0, 8'd255);
        default: set_config(MsW'($urandom_range(2, 600)), MsW'($urandom_range(0, 400)),
                            MsW'($urandom_range(0, 300)), MsW'($urandom_range(0, 300)),
                            1'($urandom), LvlW'($urandom));
      endcase
      tx_calm = (ph == 2);
      rx_calm = (ph == 4);
      add_random_polls(PhaseItems);
      wait_drained();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
